// File: hw/rtl/scd_pkg.sv
// Shared types and constants for the stick radial clamp and deadzone block.
package scd_pkg;

  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps = 15;
  localparam logic [14:0] DeadZoneReset = 15'd2048;
  localparam logic [15:0] UnitR2 = 16'd16129;
  localparam logic [15:0] UnitDen = 16'd32512;
  localparam logic [14:0] FullScale = 15'd32767;

  typedef struct packed {
    logic vld;
    logic [19:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
    logic [7:0] xi;
    logic [7:0] yi;
    logic in_circle;
  } sq_t;

  typedef struct packed {
    logic vld;
    logic [15:0] rem;
    logic [14:0] quo;
    logic [14:0] num;
    logic [15:0] den;
    logic neg;
  } dv_t;

endpackage

// File: hw/rtl/scd_sqrt_cell.sv
// One restoring square root cell that resolves one root bit per stage.
module scd_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  scd_pkg::sq_t d_in,
  output scd_pkg::sq_t d_out
);
  import scd_pkg::*;

  sq_t d_r;
  sq_t d_nxt;
  logic [19:0] rs;
  logic [19:0] trial;
  logic ge;

  always_comb begin
    rs = {d_in.rem[17:0], d_in.rad[31:30]};
    trial = {2'b00, d_in.root, 2'b01};
    ge = (rs >= trial);
    d_nxt = d_in;
    d_nxt.rem = ge ? (rs - trial) : rs;
    d_nxt.root = {d_in.root[14:0], ge};
    d_nxt.rad = {d_in.rad[29:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.rem <= d_nxt.rem;
      d_r.root <= d_nxt.root;
      d_r.rad <= d_nxt.rad;
      d_r.xi <= d_nxt.xi;
      d_r.yi <= d_nxt.yi;
      d_r.in_circle <= d_nxt.in_circle;
    end
  end

  assign d_out = d_r;

endmodule

// File: hw/rtl/scd_div_cell.sv
// One restoring division cell that resolves one quotient bit per stage.
module scd_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  scd_pkg::dv_t d_in,
  output scd_pkg::dv_t d_out
);
  import scd_pkg::*;

  dv_t d_r;
  dv_t d_nxt;
  logic [16:0] rs;
  logic ge;

  always_comb begin
    rs = {d_in.rem, d_in.num[14]};
    ge = (rs >= {1'b0, d_in.den});
    d_nxt = d_in;
    d_nxt.rem = ge ? 16'(rs - {1'b0, d_in.den}) : rs[15:0];
    d_nxt.quo = {d_in.quo[13:0], ge};
    d_nxt.num = {d_in.num[13:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r.vld <= d_nxt.vld;
    end
    if (en) begin
      d_r.rem <= d_nxt.rem;
      d_r.quo <= d_nxt.quo;
      d_r.num <= d_nxt.num;
      d_r.den <= d_nxt.den;
      d_r.neg <= d_nxt.neg;
    end
  end

  assign d_out = d_r;

endmodule

// File: hw/rtl/stick_radial_clamp_deadzone.sv
// Top level of the stick radial clamp and square deadzone block.
// Each accepted input transaction passes through an input register, a single chain
// of 16 square root cells, a divider input register, 15 divider cells per axis and
// the output register, at one transaction per cycle; the whole chain stalls only
// while the output register holds a result that is not taken. Reset is synchronous
// and active low; it empties the chain and sets dead_zone to 2048.
module stick_radial_clamp_deadzone (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_raw_x,
  input  logic [7:0]  in_raw_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_dead_zone
);
  import scd_pkg::*;

  logic adv;
  logic [14:0] dead_zone_r;
  sq_t sq [0:SqrtSteps];
  sq_t sq0_nxt;
  sq_t sq0_r;
  logic [7:0] xi;
  logic [7:0] yi;
  logic [15:0] r2;
  dv_t dx [0:DivSteps];
  dv_t dy [0:DivSteps];
  dv_t dx0_r;
  dv_t dy0_r;
  dv_t dx0_nxt;
  dv_t dy0_nxt;
  logic [7:0] mag_x;
  logic [7:0] mag_y;
  logic [29:0] num_x;
  logic [29:0] num_y;
  logic [15:0] den;
  logic out_valid_r;
  logic [15:0] axis_x_r;
  logic [15:0] axis_y_r;
  logic [15:0] axis_x_nxt;
  logic [15:0] axis_y_nxt;
  logic [14:0] qx;
  logic [14:0] qy;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DeadZoneReset;
    end else if (cfg_valid) begin
      dead_zone_r <= cfg_dead_zone;
    end
  end

  always_comb begin
    xi = {~in_raw_x[7], in_raw_x[6:0]};
    yi = {in_raw_y[7], ~in_raw_y[6:0]};
    r2 = 16'(16'($signed(xi)) * 16'($signed(xi))) + 16'(16'($signed(yi)) * 16'($signed(yi)));
    sq0_nxt.vld = in_valid;
    sq0_nxt.rem = 20'd0;
    sq0_nxt.root = 16'd0;
    sq0_nxt.rad = {r2, 16'd0};
    sq0_nxt.xi = xi;
    sq0_nxt.yi = yi;
    sq0_nxt.in_circle = (r2 <= UnitR2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq0_r.vld <= 1'b0;
    end else if (adv) begin
      sq0_r.vld <= sq0_nxt.vld;
    end
    if (adv) begin
      sq0_r.rem <= sq0_nxt.rem;
      sq0_r.root <= sq0_nxt.root;
      sq0_r.rad <= sq0_nxt.rad;
      sq0_r.xi <= sq0_nxt.xi;
      sq0_r.yi <= sq0_nxt.yi;
      sq0_r.in_circle <= sq0_nxt.in_circle;
    end
  end

  assign sq[0] = sq0_r;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    scd_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (sq[i]),
      .d_out (sq[i+1])
    );
  end

  always_comb begin
    mag_x = sq[SqrtSteps].xi[7] ? 8'(-sq[SqrtSteps].xi) : sq[SqrtSteps].xi;
    mag_y = sq[SqrtSteps].yi[7] ? 8'(-sq[SqrtSteps].yi) : sq[SqrtSteps].yi;
    num_x = {22'(FullScale) * 22'(mag_x), 8'd0};
    num_y = {22'(FullScale) * 22'(mag_y), 8'd0};
    den = sq[SqrtSteps].in_circle ? UnitDen : sq[SqrtSteps].root;
    dx0_nxt.vld = sq[SqrtSteps].vld;
    dx0_nxt.rem = {1'b0, num_x[29:15]};
    dx0_nxt.quo = 15'd0;
    dx0_nxt.num = num_x[14:0];
    dx0_nxt.den = den;
    dx0_nxt.neg = sq[SqrtSteps].xi[7];
    dy0_nxt.vld = sq[SqrtSteps].vld;
    dy0_nxt.rem = {1'b0, num_y[29:15]};
    dy0_nxt.quo = 15'd0;
    dy0_nxt.num = num_y[14:0];
    dy0_nxt.den = den;
    dy0_nxt.neg = sq[SqrtSteps].yi[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx0_r.vld <= 1'b0;
      dy0_r.vld <= 1'b0;
    end else if (adv) begin
      dx0_r.vld <= dx0_nxt.vld;
      dy0_r.vld <= dy0_nxt.vld;
    end
    if (adv) begin
      dx0_r.rem <= dx0_nxt.rem;
      dx0_r.quo <= dx0_nxt.quo;
      dx0_r.num <= dx0_nxt.num;
      dx0_r.den <= dx0_nxt.den;
      dx0_r.neg <= dx0_nxt.neg;
      dy0_r.rem <= dy0_nxt.rem;
      dy0_r.quo <= dy0_nxt.quo;
      dy0_r.num <= dy0_nxt.num;
      dy0_r.den <= dy0_nxt.den;
      dy0_r.neg <= dy0_nxt.neg;
    end
  end

  assign dx[0] = dx0_r;
  assign dy[0] = dy0_r;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    scd_div_cell u_cell_x (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (dx[i]),
      .d_out (dx[i+1])
    );
    scd_div_cell u_cell_y (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d_in  (dy[i]),
      .d_out (dy[i+1])
    );
  end

  always_comb begin
    qx = dx[DivSteps].quo;
    qy = dy[DivSteps].quo;
    if ((qx < dead_zone_r) && (qy < dead_zone_r)) begin
      axis_x_nxt = 16'd0;
      axis_y_nxt = 16'd0;
    end else begin
      axis_x_nxt = dx[DivSteps].neg ? 16'(-{1'b0, qx}) : {1'b0, qx};
      axis_y_nxt = dy[DivSteps].neg ? 16'(-{1'b0, qy}) : {1'b0, qy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dx[DivSteps].vld;
    end
    if (adv) begin
      axis_x_r <= axis_x_nxt;
      axis_y_r <= axis_y_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_axis_x = axis_x_r;
  assign out_axis_y = axis_y_r;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    dx[DivSteps].vld == dy[DivSteps].vld)
    else $error("divider lanes out of step");

  a_no_min_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> axis_x_r != 16'h8000)
    else $error("axis_x out of range");

  a_no_min_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> axis_y_r != 16'h8000)
    else $error("axis_y out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> sq0_r.vld)
    else $error("accepted transaction not captured");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the stick radial clamp and square deadzone block.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0] rx;
    logic [7:0] ry;
    logic known;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
  } axis_pair_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_raw_x;
  logic [7:0] in_raw_y;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_axis_x;
  logic signed [15:0] out_axis_y;
  logic cfg_valid;
  logic cfg_ready;
  logic [14:0] cfg_dead_zone;

  logic [14:0] dz_model;
  axis_pair_t pending_axes[$];
  int errors;
  int cycle_count;
  bit hold_off;
  bit calm;
  bit sending_done;

  stick_radial_clamp_deadzone u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_axis_x(out_axis_x), .out_axis_y(out_axis_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_dead_zone(cfg_dead_zone)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic axis_pair_t clamp_stick(logic [7:0] rx, logic [7:0] ry, logic [14:0] dz);
    axis_pair_t p;
    longint xi, yi, r2, q, ox, oy;
    xi = longint'(rx) - 128;
    yi = (255 - longint'(ry)) - 128;
    r2 = xi * xi + yi * yi;
    if (r2 <= 16129) begin
      ox = (32767 * xi) / 127;
      oy = (32767 * yi) / 127;
    end else begin
      q = floor_sqrt(r2 * 65536);
      ox = (32767 * xi * 256) / q;
      oy = (32767 * yi * 256) / q;
    end
    if ((ox < 0 ? -ox : ox) < longint'(dz) && (oy < 0 ? -oy : oy) < longint'(dz)) begin
      ox = 0;
      oy = 0;
    end
    p.ax = ox[15:0];
    p.ay = oy[15:0];
    return p;
  endfunction

  task automatic send_sample(logic [7:0] rx, logic [7:0] ry, logic known,
                             logic signed [15:0] ax, logic signed [15:0] ay);
    axis_pair_t p;
    while (!calm && ($urandom_range(99) < 11)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = clamp_stick(rx, ry, dz_model);
    if (known && (p.ax !== ax || p.ay !== ay)) begin
      $display("%0t: table row %0d,%0d expected %0d,%0d but predictor gives %0d,%0d",
               $time, rx, ry, ax, ay, p.ax, p.ay);
      errors++;
    end
    if (known) begin
      p.ax = ax;
      p.ay = ay;
    end
    in_valid <= 1'b1;
    in_raw_x <= rx;
    in_raw_y <= ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_axes.push_back(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_dead_zone(logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_dead_zone <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dz_model = v;
  endtask

  task automatic random_samples(int n);
    logic [7:0] rx, ry;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          rx = 8'($urandom_range(255));
          ry = 8'($urandom_range(255));
        end
        1: begin
          rx = 8'($urandom_range(140, 116));
          ry = 8'($urandom_range(140, 116));
        end
        2: begin
          rx = $urandom_range(1) ? 8'($urandom_range(255, 230)) : 8'($urandom_range(25));
          ry = 8'($urandom_range(255));
        end
        default: begin
          rx = 8'($urandom_range(255));
          ry = $urandom_range(1) ? 8'($urandom_range(255, 230)) : 8'($urandom_range(25));
        end
      endcase
      send_sample(rx, ry, 1'b0, 16'sd0, 16'sd0);
    end
  endtask

  stim_row_t directed_rows[] = '{
    '{8'd128, 8'd127, 1'b1, 16'sd0, 16'sd0},
    '{8'd255, 8'd127, 1'b1, 16'sd32767, 16'sd0},
    '{8'd1, 8'd127, 1'b1, -16'sd32767, 16'sd0},
    '{8'd128, 8'd0, 1'b1, 16'sd0, 16'sd32767},
    '{8'd128, 8'd254, 1'b1, 16'sd0, -16'sd32767},
    '{8'd0, 8'd127, 1'b0, 16'sd0, 16'sd0},
    '{8'd128, 8'd255, 1'b0, 16'sd0, 16'sd0},
    '{8'd0, 8'd0, 1'b0, 16'sd0, 16'sd0},
    '{8'd255, 8'd255, 1'b0, 16'sd0, 16'sd0},
    '{8'd0, 8'd255, 1'b0, 16'sd0, 16'sd0},
    '{8'd255, 8'd0, 1'b0, 16'sd0, 16'sd0},
    '{8'd135, 8'd127, 1'b0, 16'sd0, 16'sd0},
    '{8'd136, 8'd127, 1'b0, 16'sd0, 16'sd0},
    '{8'd128, 8'd119, 1'b0, 16'sd0, 16'sd0},
    '{8'd218, 8'd37, 1'b0, 16'sd0, 16'sd0},
    '{8'd219, 8'd36, 1'b0, 16'sd0, 16'sd0},
    '{8'd170, 8'd85, 1'b0, 16'sd0, 16'sd0},
    '{8'd85, 8'd170, 1'b0, 16'sd0, 16'sd0}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_x = 8'd0;
    in_raw_y = 8'd0;
    cfg_valid = 1'b0;
    cfg_dead_zone = 15'd0;
    dz_model = 15'd2048;
    errors = 0;
    hold_off = 1'b0;
    calm = 1'b0;
    sending_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].rx, directed_rows[i].ry, directed_rows[i].known,
                  directed_rows[i].ax, directed_rows[i].ay);
    drain_results();
    write_dead_zone(15'd0);
    send_sample(8'd128, 8'd127, 1'b1, 16'sd0, 16'sd0);
    send_sample(8'd129, 8'd127, 1'b1, 16'sd258, 16'sd0);
    random_samples(120);
    drain_results();
    write_dead_zone(15'd32767);
    send_sample(8'd255, 8'd127, 1'b1, 16'sd32767, 16'sd0);
    send_sample(8'd200, 8'd127, 1'b1, 16'sd0, 16'sd0);
    random_samples(100);
    hold_off = 1'b1;
    random_samples(60);
    drain_results();
    write_dead_zone(15'($urandom_range(20000, 1)));
    calm = 1'b1;
    random_samples(150);
    calm = 1'b0;
    drain_results();
    write_dead_zone(15'd2048);
    random_samples(150);
    drain_results();
    sending_done = 1'b1;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    axis_pair_t exp_axes;
    if (rst_n && out_valid && out_ready) begin
      if (pending_axes.size() == 0) begin
        $display("%0t: unexpected result %0d,%0d", $time, out_axis_x, out_axis_y);
        errors++;
      end else begin
        exp_axes = pending_axes.pop_front();
        if (out_axis_x !== exp_axes.ax) begin
          $display("%0t: axis_x expected %0d actual %0d", $time, exp_axes.ax, out_axis_x);
          errors++;
        end
        if (out_axis_y !== exp_axes.ay) begin
          $display("%0t: axis_y expected %0d actual %0d", $time, exp_axes.ay, out_axis_y);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (!sending_done && cycle_count < 200000) begin
      @(posedge clk);
      cycle_count++;
    end
    if (!sending_done) begin
      $display("stick_radial_clamp_deadzone verification failed");
    end else if (errors == 0 && pending_axes.size() == 0) begin
      $display("stick_radial_clamp_deadzone verification clean");
    end else begin
      $display("stick_radial_clamp_deadzone verification failed");
    end
    $finish;
  end

endmodule

// File: stick_radial_clamp_deadzone.f
hw/rtl/scd_pkg.sv
hw/rtl/scd_sqrt_cell.sv
hw/rtl/scd_div_cell.sv
hw/rtl/stick_radial_clamp_deadzone.sv
verif/testbench.sv
